FILE: hdl/wcm_pkg.sv
// Package with shared types, constants and codes of the wildcard command matcher.
`timescale 1ns / 1ps
package wcm_pkg;
	localparam int MAX_LINE_DEF    = 128;
	localparam int MAX_PATTERN_DEF = 32;
	localparam int MAX_ENTRIES_DEF = 16;

	localparam logic [2:0] ST_NOMATCH  = 3'd0;
	localparam logic [2:0] ST_MATCH    = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_STORED   = 3'd3;
	localparam logic [2:0] ST_LINE_OVF = 3'd4;
	localparam logic [2:0] ST_REJECT   = 3'd5;

	localparam logic REQ_PATTERN = 1'b0;
	localparam logic REQ_LINE    = 1'b1;

	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_STAR = 8'h2A;

	typedef struct packed {
		logic       req_type;
		logic [7:0] char_byte;
		logic       is_last;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] entry_index;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic ld_start;   // begin trimming the buffered line
		logic trim_lo;    // advance first
		logic trim_hi;    // retreat end
		logic ent_init;   // load pattern search registers for current entry
		logic step;       // one match step
		logic tail;       // skip one trailing star
		logic next_ent;   // move to next entry
		logic rd_lo;      // read the line byte at first
		logic rd_hi;      // read the line byte at end-1
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic lo_blank;   // line byte at first is blank and first < end
		logic hi_blank;   // line byte at end-1 is blank and end > first
		logic empty;      // first == end
		logic ent_left;   // entry index below entry count
		logic t_done;     // ti == end
		logic fail;       // step failed without star
		logic tail_star;  // pi < plen and pat[pi] is a star
		logic tail_ok;    // pi == plen
	} sts_t;

	function automatic logic is_blank(input logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A || c == 8'h00;
	endfunction
endpackage

FILE: hdl/wcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wcm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/wcm_datapath.sv
// Datapath: line and pattern stores, load counters, trim and wildcard match registers.
`timescale 1ns / 1ps
module wcm_datapath #(
	parameter int MAX_LINE    = 128,
	parameter int MAX_PATTERN = 32,
	parameter int MAX_ENTRIES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  wcm_pkg::req_t     req,
	input  wcm_pkg::cmd_t     cmd,
	output wcm_pkg::sts_t     sts,
	output logic              line_ovf,
	output logic              pat_end_ok,
	output logic [3:0]        pat_idx,
	output logic [3:0]        ent_idx
);
	import wcm_pkg::*;

	localparam int LW = $clog2(MAX_LINE + 1);
	localparam int LA = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
	localparam int PW = $clog2(MAX_PATTERN + 1);
	localparam int PA = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int EW = $clog2(MAX_ENTRIES + 1);
	localparam int EA = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int SD = MAX_ENTRIES * MAX_PATTERN;
	localparam int SA = $clog2(SD);

	logic [LW-1:0] line_len_q;
	logic          line_ovf_q;
	logic [PW-1:0] pat_pos_q;
	logic          pat_ovf_q;
	logic [EW-1:0] ent_cnt_q;

	// Match registers.
	logic [LW-1:0] first_q, end_q, ti_q, mark_q;
	logic [PW-1:0] pi_q, star_q, plen_q;
	logic          have_star_q;
	logic [EW-1:0] ent_q;

	logic [7:0]    line_rd, pat_rd;
	logic [PW-1:0] len_rd;
	logic [LA-1:0] line_raddr;
	logic [SA-1:0] pat_raddr;
	logic [EA-1:0] ent_a;

	logic p_acc, l_acc, p_write, l_write, p_end_ok;

	assign p_acc   = acc && req.req_type == REQ_PATTERN;
	assign l_acc   = acc && req.req_type == REQ_LINE;
	assign p_write = p_acc && pat_pos_q < PW'(MAX_PATTERN) && ent_cnt_q < EW'(MAX_ENTRIES);
	assign l_write = l_acc && line_len_q < LW'(MAX_LINE);
	assign p_end_ok = p_acc && req.is_last && !(pat_pos_q >= PW'(MAX_PATTERN))
		&& !pat_ovf_q && ent_cnt_q < EW'(MAX_ENTRIES);
	assign ent_a   = ent_q[EA-1:0];

	// Line buffer.
	wcm_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_line (
		.clk(clk), .we(l_write), .waddr(line_len_q[LA-1:0]), .wdata(req.char_byte),
		.raddr(line_raddr), .rdata(line_rd)
	);

	// Pattern store, one row of MAX_PATTERN bytes per entry.
	wcm_ram #(.WIDTH(8), .DEPTH(SD)) u_pat (
		.clk(clk), .we(p_write),
		.waddr(SA'(ent_cnt_q[EA-1:0]) * SA'(MAX_PATTERN) + SA'(pat_pos_q[PA-1:0])),
		.wdata(req.char_byte), .raddr(pat_raddr), .rdata(pat_rd)
	);

	// Pattern length table.
	wcm_ram #(.WIDTH(PW), .DEPTH(MAX_ENTRIES)) u_len (
		.clk(clk), .we(p_end_ok), .waddr(ent_cnt_q[EA-1:0]), .wdata(pat_pos_q + PW'(1)),
		.raddr(ent_a), .rdata(len_rd)
	);

	// Read address selection: trimming reads the ends, matching reads at ti and pi.
	logic [LW-1:0] lsel;
	always_comb begin
		lsel = ti_q;
		if (cmd.rd_lo) begin
			lsel = first_q;
		end else if (cmd.rd_hi) begin
			lsel = end_q - LW'(1);
		end
		line_raddr = lsel[LA-1:0];
		pat_raddr  = SA'(ent_a) * SA'(MAX_PATTERN) + SA'(pi_q[PA-1:0]);
	end

	// Status toward the controller.
	logic pi_in;
	assign pi_in = pi_q < plen_q;
	always_comb begin
		sts.lo_blank  = first_q < end_q && is_blank(line_rd);
		sts.hi_blank  = end_q > first_q && is_blank(line_rd);
		sts.empty     = first_q == end_q;
		sts.ent_left  = ent_q < ent_cnt_q;
		sts.t_done    = ti_q == end_q;
		sts.fail      = !(pi_in && (pat_rd == CH_DOT || pat_rd == line_rd))
			&& !(pi_in && pat_rd == CH_STAR) && !have_star_q;
		sts.tail_star = pi_in && pat_rd == CH_STAR;
		sts.tail_ok   = pi_q == plen_q;
	end

	assign line_ovf   = line_ovf_q || (l_acc && line_len_q >= LW'(MAX_LINE));
	assign pat_end_ok = p_end_ok;
	assign pat_idx    = 4'(ent_cnt_q);
	assign ent_idx    = 4'(ent_q);

	// Load counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q <= '0;
			line_ovf_q <= 1'b0;
			pat_pos_q  <= '0;
			pat_ovf_q  <= 1'b0;
			ent_cnt_q  <= '0;
		end else begin
			if (l_acc) begin
				if (req.is_last) begin
					line_len_q <= '0;
					line_ovf_q <= 1'b0;
				end else if (l_write) begin
					line_len_q <= line_len_q + LW'(1);
				end else begin
					line_ovf_q <= 1'b1;
				end
			end
			if (p_acc) begin
				if (req.is_last) begin
					pat_pos_q <= '0;
					pat_ovf_q <= 1'b0;
					if (p_end_ok) begin
						ent_cnt_q <= ent_cnt_q + EW'(1);
					end
				end else if (pat_pos_q < PW'(MAX_PATTERN)) begin
					pat_pos_q <= pat_pos_q + PW'(1);
				end else begin
					pat_ovf_q <= 1'b1;
				end
			end
		end
	end

	// Trim and match registers.
	logic hit, star;
	assign hit  = pi_in && (pat_rd == CH_DOT || pat_rd == line_rd);
	assign star = pi_in && pat_rd == CH_STAR;
	always_ff @(posedge clk) begin
		if (cmd.ld_start) begin
			first_q <= '0;
			end_q   <= line_len_q + LW'(1);
			ent_q   <= '0;
		end
		if (cmd.trim_lo) begin
			first_q <= first_q + LW'(1);
		end
		if (cmd.trim_hi) begin
			end_q <= end_q - LW'(1);
		end
		if (cmd.ent_init) begin
			ti_q        <= first_q;
			pi_q        <= '0;
			have_star_q <= 1'b0;
			plen_q      <= len_rd;
		end
		if (cmd.step) begin
			if (hit) begin
				ti_q <= ti_q + LW'(1);
				pi_q <= pi_q + PW'(1);
			end else if (star) begin
				have_star_q <= 1'b1;
				star_q      <= pi_q;
				mark_q      <= ti_q;
				pi_q        <= pi_q + PW'(1);
			end else begin
				pi_q   <= star_q + PW'(1);
				mark_q <= mark_q + LW'(1);
				ti_q   <= mark_q + LW'(1);
			end
		end
		if (cmd.tail) begin
			pi_q <= pi_q + PW'(1);
		end
		if (cmd.next_ent) begin
			ent_q <= ent_q + EW'(1);
		end
	end
endmodule

FILE: hdl/wcm_ctrl.sv
// Controller: sequences trimming and the pattern walk, and issues results.
`timescale 1ns / 1ps
module wcm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          acc,
	input  wcm_pkg::req_t req,
	input  wcm_pkg::sts_t sts,
	input  logic          line_ovf,
	input  logic          pat_end_ok,
	input  logic [3:0]    pat_idx,
	input  logic [3:0]    ent_idx,
	output wcm_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output wcm_pkg::rsp_t result
);
	import wcm_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_LORD  = 4'd1;
	localparam logic [3:0] S_LO    = 4'd2;
	localparam logic [3:0] S_HIRD  = 4'd3;
	localparam logic [3:0] S_HI    = 4'd4;
	localparam logic [3:0] S_ENT   = 4'd5;
	localparam logic [3:0] S_LEN   = 4'd6;
	localparam logic [3:0] S_RD    = 4'd7;
	localparam logic [3:0] S_STEP  = 4'd8;
	localparam logic [3:0] S_TAIL  = 4'd9;

	logic [3:0] state_q, state_d;
	logic       done_q, done_d;
	rsp_t       res_q, res_d;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		res_d   = res_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (acc && req.is_last) begin
					if (req.req_type == REQ_PATTERN) begin
						done_d = 1'b1;
						res_d.status      = pat_end_ok ? ST_STORED : ST_REJECT;
						res_d.entry_index = pat_end_ok ? pat_idx : 4'd0;
					end else if (line_ovf) begin
						done_d = 1'b1;
						res_d  = '{status: ST_LINE_OVF, entry_index: 4'd0};
					end else begin
						cmd.ld_start = 1'b1;
						state_d      = S_LORD;
					end
				end
			end
			S_LORD: begin
				cmd.rd_lo = 1'b1;
				state_d   = S_LO;
			end
			S_LO: begin
				if (sts.lo_blank) begin
					cmd.trim_lo = 1'b1;
					state_d     = S_LORD;
				end else begin
					state_d = S_HIRD;
				end
			end
			S_HIRD: begin
				cmd.rd_hi = 1'b1;
				state_d   = S_HI;
			end
			S_HI: begin
				if (sts.hi_blank) begin
					cmd.trim_hi = 1'b1;
					state_d     = S_HIRD;
				end else if (sts.empty) begin
					done_d  = 1'b1;
					res_d   = '{status: ST_EMPTY, entry_index: 4'd0};
					state_d = S_IDLE;
				end else begin
					state_d = S_ENT;
				end
			end
			S_ENT: begin
				if (sts.ent_left) begin
					state_d = S_LEN;
				end else begin
					done_d  = 1'b1;
					res_d   = '{status: ST_NOMATCH, entry_index: 4'd0};
					state_d = S_IDLE;
				end
			end
			S_LEN: begin
				cmd.ent_init = 1'b1;
				state_d      = S_RD;
			end
			S_RD: begin
				state_d = sts.t_done ? S_TAIL : S_STEP;
			end
			S_STEP: begin
				if (sts.fail) begin
					cmd.next_ent = 1'b1;
					state_d      = S_ENT;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_RD;
				end
			end
			S_TAIL: begin
				if (sts.tail_star) begin
					cmd.tail = 1'b1;
					state_d  = S_RD;
				end else if (sts.tail_ok) begin
					done_d  = 1'b1;
					res_d   = '{status: ST_MATCH, entry_index: ent_idx};
					state_d = S_IDLE;
				end else begin
					cmd.next_ent = 1'b1;
					state_d      = S_ENT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// The line end register starts at the full length: the count before the final
	// byte plus that byte. The hi read path addresses end-1.

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;
endmodule

FILE: hdl/wildcard_command_matcher_top.sv
// Top level of the wildcard command matcher.
//
//  Channel   Handshake            Payload
//  request   start / busy         req   (req_t: req_type, char_byte, is_last)
//  result    done, one cycle      result (rsp_t: status, entry_index)
//
// A pattern byte or a non-final line byte is taken without raising busy; a pattern end or an
// overflowed line end reports in the next cycle, also without busy. Any other line end
// holds busy while the blanks at both ends are trimmed, then while the stored patterns are
// tried in entry order until one matches or none is left, which reports no match; an
// empty line skips the walk. The result shows in the first cycle with busy low.
// Each store has a single registered read port, so the walk reads before every step.
// Reset clears counters and the controller; the stores keep no reset contents.
// The receiver cannot stall results.
`timescale 1ns / 1ps
module wildcard_command_matcher_top #(
	parameter int MAX_LINE    = wcm_pkg::MAX_LINE_DEF,
	parameter int MAX_PATTERN = wcm_pkg::MAX_PATTERN_DEF,
	parameter int MAX_ENTRIES = wcm_pkg::MAX_ENTRIES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  wcm_pkg::req_t req,
	output logic          done,
	output wcm_pkg::rsp_t result
);
	import wcm_pkg::*;

	logic acc, line_ovf, pat_end_ok;
	logic [3:0] pat_idx, ent_idx;
	cmd_t cmd;
	sts_t sts;

	assign acc = start && !busy;

	wcm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .acc(acc), .req(req), .sts(sts),
		.line_ovf(line_ovf), .pat_end_ok(pat_end_ok), .pat_idx(pat_idx),
		.ent_idx(ent_idx), .cmd(cmd), .busy(busy), .done(done), .result(result)
	);

	wcm_datapath #(
		.MAX_LINE(MAX_LINE), .MAX_PATTERN(MAX_PATTERN), .MAX_ENTRIES(MAX_ENTRIES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .acc(acc), .req(req), .cmd(cmd), .sts(sts),
		.line_ovf(line_ovf), .pat_end_ok(pat_end_ok), .pat_idx(pat_idx),
		.ent_idx(ent_idx)
	);
endmodule

FILE: hdl/wcm_checker.sv
// Port-level checker for the wildcard command matcher, bound to the top level.
`timescale 1ns / 1ps
module wcm_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input wcm_pkg::req_t req,
	input logic          done,
	input wcm_pkg::rsp_t result
);
	import wcm_pkg::*;

	// A result never carries an undefined status code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status <= ST_REJECT)
		else $error("undefined status code");

	// A transfer without is_last gives no result.
	a_no_res: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !req.is_last) |=> !done)
		else $error("result without final byte");

	// Only stored or matched results carry an index.
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_MATCH && result.status != ST_STORED)
		|-> result.entry_index == 4'd0)
		else $error("index on status without one");

	// A pattern end reports in the next cycle.
	a_pat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.is_last && req.req_type == REQ_PATTERN) |=> done)
		else $error("pattern end not reported");
endmodule

bind wildcard_command_matcher_top wcm_checker u_wcm_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
	.done(done), .result(result)
);

FILE: tb/tb_top.sv
// Self-checking testbench for the wildcard command matcher.
`timescale 1ns / 1ps
module tb_top;
	import wcm_pkg::*;

	localparam int LINE_CAP      = 128;
	localparam int PAT_CAP       = 32;
	localparam int ENTRY_CAP     = 16;
	localparam int RANDOM_ITEMS  = 1600;
	localparam int CYCLE_LIMIT   = 1000000000;
	localparam int REPORT_LIMIT  = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic done;
	rsp_t result;

	wildcard_command_matcher_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result)
	);

	always #6 clk = ~clk;

	// Shadow copy of the matcher state, updated on every accepted transfer.
	logic [7:0] line_mem [LINE_CAP];
	int         line_len = 0;
	bit         line_ovf = 1'b0;
	logic [7:0] pat_mem [ENTRY_CAP][PAT_CAP];
	int         pat_len [ENTRY_CAP];
	int         n_entries = 0;
	int         pat_pos = 0;
	bit         pat_ovf = 1'b0;

	rsp_t pending_rsp [$];
	rsp_t last_rsp = '0;
	int   mismatches = 0;
	int   cycles = 0;
	int   items_sent = 0;
	int   burst_left = 0;

	function automatic bit blank_byte(logic [7:0] c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A || c == 8'h00;
	endfunction

	// Star-and-dot match of the trimmed line against one stored entry.
	function automatic bit wild_hit(int first, int tlen, int e);
		int ti = 0;
		int pi = 0;
		int star = 0;
		int mark = 0;
		bit have_star = 1'b0;
		int plen = pat_len[e];
		while (ti < tlen) begin
			if (pi < plen && (pat_mem[e][pi] == CH_DOT || pat_mem[e][pi] == line_mem[first + ti])) begin
				ti++;
				pi++;
			end else if (pi < plen && pat_mem[e][pi] == CH_STAR) begin
				have_star = 1'b1;
				star = pi;
				mark = ti;
				pi++;
			end else if (have_star) begin
				pi = star + 1;
				mark++;
				ti = mark;
			end else begin
				return 1'b0;
			end
		end
		while (pi < plen && pat_mem[e][pi] == CH_STAR)
			pi++;
		return pi == plen;
	endfunction

	// Advances the shadow state by one transfer and queues the result it causes.
	function automatic void predict_match(req_t r);
		rsp_t o;
		int first;
		int stop;
		o = '0;
		if (r.req_type == REQ_PATTERN) begin
			if (pat_pos >= PAT_CAP) begin
				pat_ovf = 1'b1;
			end else begin
				if (n_entries < ENTRY_CAP)
					pat_mem[n_entries][pat_pos] = r.char_byte;
				pat_pos++;
			end
			if (!r.is_last)
				return;
			if (pat_ovf || n_entries >= ENTRY_CAP) begin
				o.status = ST_REJECT;
			end else begin
				pat_len[n_entries] = pat_pos;
				o.status = ST_STORED;
				o.entry_index = n_entries[3:0];
				n_entries++;
			end
			pat_pos = 0;
			pat_ovf = 1'b0;
		end else begin
			if (line_len >= LINE_CAP)
				line_ovf = 1'b1;
			else
				line_mem[line_len++] = r.char_byte;
			if (!r.is_last)
				return;
			if (line_ovf) begin
				o.status = ST_LINE_OVF;
			end else begin
				first = 0;
				stop = line_len;
				while (first < stop && blank_byte(line_mem[first]))
					first++;
				while (stop > first && blank_byte(line_mem[stop - 1]))
					stop--;
				if (first == stop) begin
					o.status = ST_EMPTY;
				end else begin
					o.status = ST_NOMATCH;
					for (int e = 0; e < n_entries; e++) begin
						if (wild_hit(first, stop - first, e)) begin
							o.status = ST_MATCH;
							o.entry_index = e[3:0];
							break;
						end
					end
				end
			end
			line_len = 0;
			line_ovf = 1'b0;
		end
		pending_rsp.push_back(o);
	endfunction

	function automatic void report_mismatch(string what, rsp_t want, rsp_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0s: expected status %0d index %0d, got status %0d index %0d",
				what, want.status, want.entry_index, got.status, got.entry_index);
	endfunction

	// Result checking comes before prediction, since a result never belongs to
	// the transfer of the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				last_rsp = result;
				if (pending_rsp.size() == 0) begin
					report_mismatch("unexpected result", '0, result);
				end else begin
					if (result.status !== pending_rsp[0].status ||
						result.entry_index !== pending_rsp[0].entry_index)
						report_mismatch("result", pending_rsp[0], result);
					void'(pending_rsp.pop_front());
				end
			end
			if (start && !busy)
				predict_match(req);
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// One transfer; when a burst runs out, an idle gap comes first unless a random draw skips it. Busy is
	// looked at in the middle of the cycle so the accepting edge is known exactly.
	task automatic send_byte(logic kind, logic [7:0] b, logic last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		req <= '{req_type: kind, char_byte: b, is_last: last};
		@(negedge clk);
		while (busy !== 1'b0)
			@(negedge clk);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic send_seq(logic kind, logic [7:0] s [$]);
		for (int i = 0; i < s.size(); i++)
			send_byte(kind, s[i], i == s.size() - 1);
	endtask

	// Sends a pattern and a line with their transfers mixed at random.
	task automatic send_mixed(logic [7:0] p [$], logic [7:0] l [$]);
		int pi = 0;
		int li = 0;
		while (pi < p.size() || li < l.size()) begin
			if (li >= l.size() || (pi < p.size() && $urandom_range(0, 1))) begin
				send_byte(REQ_PATTERN, p[pi], pi == p.size() - 1);
				pi++;
			end else begin
				send_byte(REQ_LINE, l[li], li == l.size() - 1);
				li++;
			end
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 6))
			0: return 8'h61;
			1: return 8'h62;
			2: return 8'h63;
			3: return CH_DOT;
			4: return CH_STAR;
			5: return 8'h20;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Directed rows: text, then a run of a fill byte; fixed rows carry a typed result.
	typedef struct {
		logic       kind;
		string      text;
		int         nfill;
		logic [7:0] fill;
		bit         fixed;
		rsp_t       want;
	} plan_row_t;

	plan_row_t plan [$];

	initial begin
		logic [7:0] s [$];
		logic [7:0] p [$];
		int e;
		int n;
		plan.push_back('{REQ_LINE, " ", 0, 8'h00, 1'b1, '{ST_EMPTY, 4'd0}});
		plan.push_back('{REQ_LINE, "abc", 0, 8'h00, 1'b1, '{ST_NOMATCH, 4'd0}});
		plan.push_back('{REQ_PATTERN, "a*c", 0, 8'h00, 1'b1, '{ST_STORED, 4'd0}});
		plan.push_back('{REQ_PATTERN, "h.llo", 0, 8'h00, 1'b1, '{ST_STORED, 4'd1}});
		plan.push_back('{REQ_LINE, " \t abbbc\015\n", 0, 8'h00, 1'b0, '0});
		plan.push_back('{REQ_LINE, "hello", 0, 8'h00, 1'b0, '0});
		plan.push_back('{REQ_LINE, "hxllo", 0, 8'h00, 1'b0, '0});
		plan.push_back('{REQ_LINE, "ac", 0, 8'h00, 1'b0, '0});
		plan.push_back('{REQ_LINE, ".*", 0, 8'h00, 1'b0, '0});
		plan.push_back('{REQ_LINE, "abd", 0, 8'h00, 1'b0, '0});
		plan.push_back('{REQ_LINE, "", 129, 8'h61, 1'b1, '{ST_LINE_OVF, 4'd0}});
		plan.push_back('{REQ_LINE, "", 3, 8'h00, 1'b1, '{ST_EMPTY, 4'd0}});
		plan.push_back('{REQ_PATTERN, "", 33, 8'h61, 1'b1, '{ST_REJECT, 4'd0}});
		plan.push_back('{REQ_PATTERN, "", 32, CH_STAR, 1'b1, '{ST_STORED, 4'd2}});
		plan.push_back('{REQ_LINE, "", 128, 8'h78, 1'b1, '{ST_MATCH, 4'd2}});
		plan.push_back('{REQ_LINE, "", 1, 8'hFF, 1'b0, '0});
		plan.push_back('{REQ_PATTERN, "", 1, 8'hFF, 1'b1, '{ST_STORED, 4'd3}});
		plan.push_back('{REQ_LINE, "", 1, 8'hFF, 1'b0, '0});
		plan.push_back('{REQ_PATTERN, "a", 0, 8'h00, 1'b1, '{ST_STORED, 4'd4}});
		plan.push_back('{REQ_LINE, "a ", 0, 8'h00, 1'b0, '0});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part; each row completes before the next so fixed rows can be read back.
		foreach (plan[r]) begin
			s.delete();
			for (int i = 0; i < plan[r].text.len(); i++)
				s.push_back(plan[r].text.getc(i));
			repeat (plan[r].nfill) s.push_back(plan[r].fill);
			send_seq(plan[r].kind, s);
			drain_results();
			if (plan[r].fixed && last_rsp !== plan[r].want)
				report_mismatch("directed row", plan[r].want, last_rsp);
		end

		// Random part: mostly lines built from stored entries, plus new entries and noise.
		while (items_sent < RANDOM_ITEMS) begin
			s.delete();
			p.delete();
			n = $urandom_range(0, 99);
			if (n < 65 && n_entries > 0) begin
				e = $urandom_range(0, n_entries - 1);
				repeat ($urandom_range(0, 2)) s.push_back(8'h20);
				for (int i = 0; i < pat_len[e]; i++) begin
					if (pat_mem[e][i] == CH_DOT)
						s.push_back(pick_char());
					else if (pat_mem[e][i] == CH_STAR)
						repeat ($urandom_range(0, 3)) s.push_back(pick_char());
					else
						s.push_back(pat_mem[e][i]);
				end
				if (s.size() > 0 && $urandom_range(0, 4) == 0)
					s[$urandom_range(0, s.size() - 1)] = pick_char();
				if ($urandom_range(0, 2) == 0)
					s.push_back(8'h0A);
				if (s.size() == 0)
					s.push_back(pick_char());
				send_seq(REQ_LINE, s);
			end else if (n < 85) begin
				repeat (($urandom_range(0, 9) == 0) ? $urandom_range(33, 38) : $urandom_range(1, 8))
					p.push_back(pick_char());
				if ($urandom_range(0, 1)) begin
					repeat ($urandom_range(1, 10)) s.push_back(pick_char());
					send_mixed(p, s);
				end else begin
					send_seq(REQ_PATTERN, p);
				end
			end else begin
				repeat (($urandom_range(0, 39) == 0) ? $urandom_range(129, 133) : $urandom_range(1, 12))
					s.push_back(8'($urandom_range(0, 255)));
				send_seq(REQ_LINE, s);
			end
			if ($urandom_range(0, 49) == 0)
				drain_results();
		end

		drain_results();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

FILE: filelist.f
hdl/wcm_pkg.sv
hdl/wcm_ram.sv
hdl/wcm_datapath.sv
hdl/wcm_ctrl.sv
hdl/wildcard_command_matcher_top.sv
hdl/wcm_checker.sv
tb/tb_top.sv
